/* rtl/afac_pkg.sv */
// ----------------------------------------------------------------------------
// afac_pkg
// Shared types and constants of the accelerometer frame calibration block.
// ----------------------------------------------------------------------------
package afac_pkg;

  localparam int TYPE_W   = 8;
  localparam int WORD_W   = 48;
  localparam int LANE_W   = 16;
  localparam int DIFF_W   = 17;
  localparam int PROD_W   = LANE_W + DIFF_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int ACCEL_W  = 32;
  localparam int COUNT_W  = 32;
  localparam int AXES     = 3;
  localparam int SCALE_SHIFT = 17;
  localparam int SCALED_W = ACC_W + 14;

  localparam int COUNTER_WIDTH_DEF = 32;
  localparam int Q_DEPTH = 2;

  localparam logic signed [13:0] SCALE_MUL = 14'sd5018;
  localparam logic [1:0] LAST_IDX = 2'(AXES - 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_CODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIASES    = 3'd4;

  localparam logic [TYPE_W-1:0] TYPE_CODE_RST = 8'd81;
  localparam logic [WORD_W-1:0] ROW_X_RST = 48'h0000_0000_2000;
  localparam logic [WORD_W-1:0] ROW_Y_RST = 48'h0000_2000_0000;
  localparam logic [WORD_W-1:0] ROW_Z_RST = 48'h2000_0000_0000;

  typedef struct packed {
    logic [TYPE_W-1:0]                       type_code;
    logic [AXES-1:0][AXES-1:0][LANE_W-1:0]   coef;    // coef[row][col]
    logic [AXES-1:0][LANE_W-1:0]             bias;
  } afac_cfg_t;

  typedef struct packed {
    logic [AXES-1:0][DIFF_W-1:0] diff;
    logic [COUNT_W-1:0]          count;
  } afac_item_t;

  typedef struct packed {
    logic       push;
    afac_item_t item;
  } afac_q_wr_t;

  typedef struct packed {
    logic       valid;
    afac_item_t item;
  } afac_q_rd_t;

endpackage

/* rtl/afac_ifs.sv */
// ----------------------------------------------------------------------------
// afac channel interfaces
// Frame input channel and calibrated acceleration output channel.
// ----------------------------------------------------------------------------
interface afac_frame_if;
  logic                        valid;
  logic                        ready;
  logic [afac_pkg::TYPE_W-1:0] frame_type;
  logic [afac_pkg::WORD_W-1:0] payload;

  modport source(output valid, frame_type, payload, input ready);
  modport sink(input valid, frame_type, payload, output ready);
endinterface

interface afac_accel_if;
  logic                                valid;
  logic                                ready;
  logic signed [afac_pkg::ACCEL_W-1:0] accel_x;
  logic signed [afac_pkg::ACCEL_W-1:0] accel_y;
  logic signed [afac_pkg::ACCEL_W-1:0] accel_z;
  logic        [afac_pkg::COUNT_W-1:0] frame_count;

  modport source(output valid, accel_x, accel_y, accel_z, frame_count, input ready);
  modport sink(input valid, accel_x, accel_y, accel_z, frame_count, output ready);
endinterface

/* rtl/afac_front.sv */
// ----------------------------------------------------------------------------
// afac_front
// Accepts frames, drops non-acceleration types, removes biases and counts.
// ----------------------------------------------------------------------------
module afac_front #(
  parameter int COUNTER_WIDTH = afac_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  afac_frame_if.sink           frame_in,
  input  afac_pkg::afac_cfg_t  cfg,
  input  logic                 q_full,
  output afac_pkg::afac_q_wr_t q_wr
);

  logic [COUNTER_WIDTH-1:0]      cnt;
  logic [COUNTER_WIDTH-1:0]      cnt_next;
  logic [afac_pkg::COUNT_W-1:0]  count_low;
  logic                          is_accel;
  logic                          accept;

  assign frame_in.ready = !q_full;
  assign accept   = frame_in.valid && !q_full;
  assign is_accel = (frame_in.frame_type == cfg.type_code);
  assign cnt_next = cnt + COUNTER_WIDTH'(1);

  if (COUNTER_WIDTH >= afac_pkg::COUNT_W) begin : g_wide
    assign count_low = cnt_next[afac_pkg::COUNT_W-1:0];
  end else begin : g_narrow
    assign count_low = {{(afac_pkg::COUNT_W-COUNTER_WIDTH){1'b0}}, cnt_next};
  end

  always_comb begin
    q_wr.push       = accept && is_accel;
    q_wr.item.count = count_low;
    for (int k = 0; k < afac_pkg::AXES; k++) begin
      q_wr.item.diff[k] =
        $signed({frame_in.payload[k*afac_pkg::LANE_W + afac_pkg::LANE_W-1],
                 frame_in.payload[k*afac_pkg::LANE_W +: afac_pkg::LANE_W]}) -
        $signed({cfg.bias[k][afac_pkg::LANE_W-1], cfg.bias[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (q_wr.push) begin
      cnt <= cnt_next;
    end
  end

endmodule

/* rtl/afac_queue.sv */
// ----------------------------------------------------------------------------
// afac_queue
// Short register FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module afac_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  afac_pkg::afac_q_wr_t q_wr,
  input  logic                 pop,
  output logic                 full,
  output afac_pkg::afac_q_rd_t q_rd
);

  localparam int PTR_W = $clog2(afac_pkg::Q_DEPTH);
  localparam int LVL_W = PTR_W + 1;

  afac_pkg::afac_item_t entries [afac_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [LVL_W-1:0] level;
  logic             do_push;
  logic             do_pop;

  assign full       = (level == LVL_W'(afac_pkg::Q_DEPTH));
  assign q_rd.valid = (level != '0);
  assign q_rd.item  = entries[rptr];
  assign do_push    = q_wr.push && !full;
  assign do_pop     = pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= q_wr.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (do_push) wptr <= wptr + PTR_W'(1);
      if (do_pop)  rptr <= rptr + PTR_W'(1);
      if (do_push && !do_pop) begin
        level <= level + LVL_W'(1);
      end else if (do_pop && !do_push) begin
        level <= level - LVL_W'(1);
      end
    end
  end

endmodule

/* rtl/afac_back.sv */
// ----------------------------------------------------------------------------
// afac_back
// Matrix multiply and scaling, one product per cycle, one row at a time.
// ----------------------------------------------------------------------------
module afac_back (
  input  logic                 clk,
  input  logic                 rst,
  input  afac_pkg::afac_cfg_t  cfg,
  input  afac_pkg::afac_q_rd_t q_rd,
  output logic                 pop,
  afac_accel_if.source         accel_out
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_SCALE = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [afac_pkg::AXES-1:0][afac_pkg::DIFF_W-1:0] diff;
  logic [afac_pkg::COUNT_W-1:0]         count;
  logic [1:0]                           row;
  logic [1:0]                           col;
  logic signed [afac_pkg::ACC_W-1:0]    acc;
  logic signed [afac_pkg::PROD_W-1:0]   prod;
  logic signed [afac_pkg::SCALED_W-1:0] scaled;
  logic signed [afac_pkg::ACCEL_W-1:0]  res [afac_pkg::AXES];

  assign prod   = $signed(cfg.coef[row][col]) * $signed(diff[col]);
  assign scaled = acc * afac_pkg::SCALE_MUL;
  assign pop    = (state == S_IDLE) && q_rd.valid;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (q_rd.valid) state_next = S_MAC;
      S_MAC:   if (col == afac_pkg::LAST_IDX) state_next = S_SCALE;
      S_SCALE: state_next = (row == afac_pkg::LAST_IDX) ? S_OUT : S_MAC;
      S_OUT:   if (accel_out.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        diff  <= q_rd.item.diff;
        count <= q_rd.item.count;
        row   <= '0;
        col   <= '0;
        acc   <= '0;
      end
      S_MAC: begin
        acc <= acc + afac_pkg::ACC_W'(prod);
        col <= (col == afac_pkg::LAST_IDX) ? 2'd0 : col + 2'd1;
      end
      S_SCALE: begin
        // floor(S * 5018 / 2^17) by arithmetic shift
        res[row] <= scaled[afac_pkg::SCALED_W-1 -: afac_pkg::ACCEL_W];
        acc      <= '0;
        row      <= row + 2'd1;
      end
      default: ;
    endcase
  end

  assign accel_out.valid       = (state == S_OUT);
  assign accel_out.accel_x     = res[0];
  assign accel_out.accel_y     = res[1];
  assign accel_out.accel_z     = res[2];
  assign accel_out.frame_count = count;

endmodule

/* rtl/accel_frame_affine_calibration_core.sv */
// ----------------------------------------------------------------------------
// accel_frame_affine_calibration_core
// Accelerometer frame calibration: bias removal, 3x3 matrix, scaling.
// ----------------------------------------------------------------------------
// Usage:
//   frame_in takes one word per frame (frame_type, payload). Frames whose
//   type differs from the type code register are consumed and dropped.
//   For acceleration frames, accel_out delivers one word with three Q15.16
//   accelerations and the wrapping frame count.
//   Configuration is written through cfg_we/cfg_index/cfg_data while the
//   block is idle; unknown indexes are ignored.
// Timing:
//   The front removes biases and queues the frame in the cycle it is taken.
//   The back runs one 16x17 multiply-accumulate per cycle through the nine
//   matrix terms plus one scaling multiply per row, each on its own
//   multiplier. It takes the next frame from the queue only after the
//   receiver has taken the output word of the last one.
// Reset: clears the queue, the sequencer and the frame counter, and loads
//   the default configuration (identity matrix, zero biases, type 81).
// Stall: a held output word stalls the back; the two-entry queue keeps the
//   input open until it fills.
// ----------------------------------------------------------------------------
module accel_frame_affine_calibration_core #(
  parameter int COUNTER_WIDTH = afac_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  afac_frame_if.sink                     frame_in,
  afac_accel_if.source                   accel_out,
  input  logic                           cfg_we,
  input  logic [afac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afac_pkg::WORD_W-1:0]    cfg_data
);

  afac_pkg::afac_cfg_t  cfg;
  afac_pkg::afac_q_wr_t q_wr;
  afac_pkg::afac_q_rd_t q_rd;
  logic                 q_full;
  logic                 pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.type_code <= afac_pkg::TYPE_CODE_RST;
      cfg.coef[0]   <= afac_pkg::ROW_X_RST;
      cfg.coef[1]   <= afac_pkg::ROW_Y_RST;
      cfg.coef[2]   <= afac_pkg::ROW_Z_RST;
      cfg.bias      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        afac_pkg::REG_TYPE_CODE: cfg.type_code <= cfg_data[afac_pkg::TYPE_W-1:0];
        afac_pkg::REG_ROW_X:     cfg.coef[0]   <= cfg_data;
        afac_pkg::REG_ROW_Y:     cfg.coef[1]   <= cfg_data;
        afac_pkg::REG_ROW_Z:     cfg.coef[2]   <= cfg_data;
        afac_pkg::REG_BIASES:    cfg.bias      <= cfg_data;
        default: ;
      endcase
    end
  end

  afac_front #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .frame_in (frame_in),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_wr     (q_wr)
  );

  afac_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .q_wr (q_wr),
    .pop  (pop),
    .full (q_full),
    .q_rd (q_rd)
  );

  afac_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_rd      (q_rd),
    .pop       (pop),
    .accel_out (accel_out)
  );

endmodule

/* rtl/afac_checker.sv */
// ----------------------------------------------------------------------------
// afac_checker
// Port-level checks of the calibration core, bound to the top level.
// ----------------------------------------------------------------------------
module afac_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [afac_pkg::ACCEL_W-1:0] accel_x,
  input logic        [afac_pkg::COUNT_W-1:0] frame_count
);

  // a word on hold stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(accel_x) && $stable(frame_count))
    else $error("output word changed while stalled");

  // reset empties the queue and the output stage
  a_reset_state: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("queue or output not cleared by reset");

  // the datapath is registered, so no word right after reset
  a_min_latency: assert property (@(posedge clk)
    $rose(out_valid) |-> !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3))
    else $error("output word too soon after reset");

endmodule

bind accel_frame_affine_calibration_core afac_checker u_afac_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (frame_in.ready),
  .out_valid   (accel_out.valid),
  .out_ready   (accel_out.ready),
  .accel_x     (accel_out.accel_x),
  .frame_count (accel_out.frame_count)
);

/* tb/sv/afac_accel_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afac_accel_checker
// Watches the frame and acceleration channels and the register write port,
// keeps its own copy of the calibration settings and frame counter, predicts
// each calibrated word and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
module afac_accel_checker (
  input  logic                           clk,
  input  logic                           rst,
  afac_frame_if                          frame_mon,
  afac_accel_if                          accel_mon,
  input  logic                           cfg_we,
  input  logic [afac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afac_pkg::WORD_W-1:0]    cfg_data,
  output int                             errors,
  output int                             pending
);

  localparam int TYPE_W  = afac_pkg::TYPE_W;
  localparam int WORD_W  = afac_pkg::WORD_W;
  localparam int LANE_W  = afac_pkg::LANE_W;
  localparam int ACCEL_W = afac_pkg::ACCEL_W;
  localparam int COUNT_W = afac_pkg::COUNT_W;

  typedef struct {
    logic signed [ACCEL_W-1:0] ax;
    logic signed [ACCEL_W-1:0] ay;
    logic signed [ACCEL_W-1:0] az;
    logic        [COUNT_W-1:0] count;
  } accel_word_t;

  accel_word_t                            expected_accel_q[$];
  logic [TYPE_W-1:0]                      type_code;
  logic [WORD_W-1:0]                      row_x, row_y, row_z;
  logic [WORD_W-1:0]                      biases;
  logic [afac_pkg::COUNTER_WIDTH_DEF-1:0] accel_frames_seen;

  function automatic longint lane(input logic [WORD_W-1:0] word, input int k);
    return longint'($signed(word[k*LANE_W +: LANE_W]));
  endfunction

  // exact dot product, then x*5018 >>> 17 (floor)
  function automatic logic signed [ACCEL_W-1:0] calibrate_row(
      input logic [WORD_W-1:0] row, input longint d0, d1, d2);
    longint sum;
    longint scaled;
    sum = lane(row, 0) * d0 + lane(row, 1) * d1 + lane(row, 2) * d2;
    scaled = (sum * longint'(afac_pkg::SCALE_MUL)) >>> afac_pkg::SCALE_SHIFT;
    return scaled[ACCEL_W-1:0];
  endfunction

  task automatic check_field(input string name, input logic signed [ACCEL_W:0] want,
                             input logic signed [ACCEL_W:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    accel_word_t want;
    longint      d0, d1, d2;
    if (rst) begin
      type_code         = afac_pkg::TYPE_CODE_RST;
      row_x             = afac_pkg::ROW_X_RST;
      row_y             = afac_pkg::ROW_Y_RST;
      row_z             = afac_pkg::ROW_Z_RST;
      biases            = '0;
      accel_frames_seen = '0;
      expected_accel_q.delete();
    end else begin
      // frame first: a write at this edge only affects later frames
      if (frame_mon.valid && frame_mon.ready && frame_mon.frame_type == type_code) begin
        d0 = lane(frame_mon.payload, 0) - lane(biases, 0);
        d1 = lane(frame_mon.payload, 1) - lane(biases, 1);
        d2 = lane(frame_mon.payload, 2) - lane(biases, 2);
        accel_frames_seen = accel_frames_seen + 1'b1;
        want.ax    = calibrate_row(row_x, d0, d1, d2);
        want.ay    = calibrate_row(row_y, d0, d1, d2);
        want.az    = calibrate_row(row_z, d0, d1, d2);
        want.count = accel_frames_seen[COUNT_W-1:0];
        expected_accel_q.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_index)
          afac_pkg::REG_TYPE_CODE: type_code = cfg_data[TYPE_W-1:0];
          afac_pkg::REG_ROW_X:     row_x     = cfg_data;
          afac_pkg::REG_ROW_Y:     row_y     = cfg_data;
          afac_pkg::REG_ROW_Z:     row_z     = cfg_data;
          afac_pkg::REG_BIASES:    biases    = cfg_data;
          default: ;
        endcase
      end
      if (accel_mon.valid && accel_mon.ready) begin
        if (expected_accel_q.size() == 0) begin
          errors++;
          $display("%0t unexpected word: expected none actual x %0d y %0d z %0d count %0d",
                   $time, accel_mon.accel_x, accel_mon.accel_y, accel_mon.accel_z,
                   accel_mon.frame_count);
        end else begin
          want = expected_accel_q.pop_front();
          check_field("accel_x", {want.ax[ACCEL_W-1], want.ax},
                      {accel_mon.accel_x[ACCEL_W-1], accel_mon.accel_x});
          check_field("accel_y", {want.ay[ACCEL_W-1], want.ay},
                      {accel_mon.accel_y[ACCEL_W-1], accel_mon.accel_y});
          check_field("accel_z", {want.az[ACCEL_W-1], want.az},
                      {accel_mon.accel_z[ACCEL_W-1], accel_mon.accel_z});
          check_field("frame_count", {1'b0, want.count}, {1'b0, accel_mon.frame_count});
        end
      end
    end
    pending <= expected_accel_q.size();
  end

endmodule

/* tb/sv/tb_accel_frame_affine_calibration_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_frame_affine_calibration_core
// Drives sensor frames and calibration settings into the core: a directed
// set of edge values, then random phases under several settings with random
// idling on both channels, a long output hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb_accel_frame_affine_calibration_core;

  localparam int TYPE_W          = afac_pkg::TYPE_W;
  localparam int WORD_W          = afac_pkg::WORD_W;
  localparam int LANE_W          = afac_pkg::LANE_W;
  localparam int CFG_IDX_W       = afac_pkg::CFG_IDX_W;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int IDLE_PCT        = 21;
  localparam int ACCEL_PCT       = 75;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 40;
  localparam int TIMEOUT_NS      = 5_000_000;
  localparam int PAD_W           = WORD_W - TYPE_W;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;
  int                   errors;
  int                   pending;
  bit                   no_idle;
  bit                   hold_req;
  bit                   offering;
  logic [TYPE_W-1:0]    accel_code;

  afac_frame_if frame_if();
  afac_accel_if accel_if();

  accel_frame_affine_calibration_core u_top (
    .clk       (clk),
    .rst       (rst),
    .frame_in  (frame_if),
    .accel_out (accel_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  afac_accel_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .frame_mon (frame_if),
    .accel_mon (accel_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL accel_frame_affine_calibration_core");
    $finish;
  end

  // output side: random stalls, a counted hold-off on request
  initial begin : receiver
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    accel_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        accel_if.ready <= 1'b0;
        hold_left--;
      end else begin
        accel_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  function automatic logic [LANE_W-1:0] pick_lane(input bit edgy);
    if (edgy) begin
      case ($urandom_range(0, 3))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        2:       return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    return LANE_W'($urandom);
  endfunction

  function automatic logic [WORD_W-1:0] pick_word(input bit edgy);
    return {pick_lane(edgy), pick_lane(edgy), pick_lane(edgy)};
  endfunction

  task automatic lower_valid;
    if (offering) begin
      frame_if.valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_frame(input logic [TYPE_W-1:0] code, input logic [WORD_W-1:0] word);
    if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      lower_valid();
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    frame_if.valid      <= 1'b1;
    frame_if.frame_type <= code;
    frame_if.payload    <= word;
    offering = 1'b1;
    do @(posedge clk); while (!frame_if.ready);
  endtask

  task automatic send_random;
    logic [TYPE_W-1:0] code;
    code = ($urandom_range(0, 99) < ACCEL_PCT) ? accel_code : TYPE_W'($urandom);
    send_frame(code, pick_word($urandom_range(0, 9) == 0));
  endtask

  // stop offering, wait for every word, then let the core settle
  task automatic drain_results;
    lower_valid();
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_setting(input logic [TYPE_W-1:0] code,
                              input logic [WORD_W-1:0] row_x, row_y, row_z, biases);
    write_reg(afac_pkg::REG_TYPE_CODE, {PAD_W'(pick_word(1'b0)), code});
    write_reg(afac_pkg::REG_ROW_X, row_x);
    write_reg(afac_pkg::REG_ROW_Y, row_y);
    write_reg(afac_pkg::REG_ROW_Z, row_z);
    write_reg(afac_pkg::REG_BIASES, biases);
    // unmapped indexes must be ignored
    for (int idx = int'(afac_pkg::REG_BIASES) + 1; idx < (1 << CFG_IDX_W); idx++)
      write_reg(CFG_IDX_W'(idx), pick_word(1'b0));
    accel_code = code;
  endtask

  initial begin : stimulus
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= afac_pkg::REG_TYPE_CODE;
    cfg_data            <= '0;
    frame_if.valid      <= 1'b0;
    frame_if.frame_type <= '0;
    frame_if.payload    <= '0;
    no_idle    = 1'b0;
    hold_req   = 1'b0;
    offering   = 1'b0;
    accel_code = afac_pkg::TYPE_CODE_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // default settings: identity, zero bias; lane extremes and odd types
    send_frame(afac_pkg::TYPE_CODE_RST, 48'h0000_0000_0000);
    send_frame(afac_pkg::TYPE_CODE_RST, 48'hFFFF_FFFF_FFFF);  // -1 counts round down
    send_frame(afac_pkg::TYPE_CODE_RST, 48'h7FFF_7FFF_7FFF);
    send_frame(afac_pkg::TYPE_CODE_RST, 48'h8000_8000_8000);
    send_frame(afac_pkg::TYPE_CODE_RST, 48'h8000_7FFF_0001);
    send_frame(8'h00, pick_word(1'b0));
    send_frame(8'hFF, pick_word(1'b0));
    send_frame(afac_pkg::TYPE_CODE_RST - 1'b1, pick_word(1'b0));
    send_frame(afac_pkg::TYPE_CODE_RST + 1'b1, pick_word(1'b0));
    drain_results();

    // largest positive sums: -4.0 coefficients times most negative difference
    load_setting(8'h00, 48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                 48'h7FFF_7FFF_7FFF);
    send_frame(8'h00, 48'h8000_8000_8000);
    send_frame(8'h00, 48'h7FFF_7FFF_7FFF);
    send_frame(8'h00, 48'hFFFF_FFFF_FFFF);
    send_frame(8'hFF, pick_word(1'b0));
    drain_results();

    // largest positive difference against max coefficients
    load_setting(8'hFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000,
                 48'h8000_8000_8000);
    send_frame(8'hFF, 48'h7FFF_7FFF_7FFF);
    send_frame(8'hFF, 48'h8000_8000_8000);
    send_frame(8'hFF, 48'h0000_0000_0000);
    send_frame(8'h00, pick_word(1'b0));
    drain_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: load_setting(TYPE_W'($urandom), pick_word(1'b0), pick_word(1'b0),
                        pick_word(1'b0), pick_word(1'b0));
        1: begin
          load_setting(afac_pkg::TYPE_CODE_RST, afac_pkg::ROW_X_RST, afac_pkg::ROW_Y_RST,
                       afac_pkg::ROW_Z_RST, pick_word(1'b0));
          no_idle = 1'b1;
        end
        2: begin
          load_setting(TYPE_W'($urandom), pick_word(1'b1), pick_word(1'b0),
                       pick_word(1'b1), pick_word(1'b0));
          hold_req = 1'b1;  // output stalls long enough to back up the input
        end
        3: load_setting(TYPE_W'($urandom), pick_word(1'b1), pick_word(1'b1),
                        pick_word(1'b1), pick_word(1'b1));
        4: load_setting(8'hFF, pick_word(1'b0), pick_word(1'b0),
                        pick_word(1'b0), pick_word(1'b1));
        default: load_setting(8'h00, pick_word(1'b0), pick_word(1'b1),
                              pick_word(1'b0), pick_word(1'b0));
      endcase
      repeat (ITEMS_PER_PHASE) send_random();
      drain_results();
      no_idle = 1'b0;
    end

    if (errors == 0 && pending == 0)
      $display("PASS accel_frame_affine_calibration_core");
    else
      $display("FAIL accel_frame_affine_calibration_core");
    $finish;
  end

endmodule
